### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rpg_pkg.sv
// Shared constants, types and helper functions of the permutation generator.
`default_nettype none
package rpg_pkg;

    localparam int POS_W         = 6;
    localparam int RANK_W        = 7;
    localparam int LEN_W         = 7;
    localparam int FRAC_IN_W     = 16;
    localparam int FRACTION_BITS = 16;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int ROW_BITS      = 8;
    localparam int ROW_IW        = 3;
    localparam int ROW_AW        = POS_W - ROW_IW;
    localparam int MAP_ROWS      = 1 << ROW_AW;
    localparam int CNT_W         = ROW_IW + 1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

    typedef struct packed {
        logic                start;
        logic                rd_en;
        logic [ROW_AW-1:0]   rd_row;
        logic                wr_en;
        logic [ROW_AW-1:0]   wr_row;
        logic [ROW_BITS-1:0] wr_data;
    } map_req_t;

    // Row contents at list start: positions at or past the length read as taken.
    function automatic logic [ROW_BITS-1:0] init_row(input logic [ROW_AW-1:0] row,
                                                     input logic [LEN_W-1:0]  len);
        logic [ROW_BITS-1:0] r;
        logic [LEN_W-1:0]    p;
        r = '0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            p    = LEN_W'({row, ROW_IW'(i)});
            r[i] = (p >= len);
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len,
                                                    input logic [LEN_W-1:0] max_len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len == '0)
            r = LEN_W'(1);
        else if (len > max_len)
            r = max_len;
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] popcount_row(input logic [ROW_BITS-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### design/rpg_map_mem.sv
// Taken-position map: 8-bit rows in a synchronous RAM with per-row valid bits.
`default_nettype none
module rpg_map_mem (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire rpg_pkg::map_req_t            req,
    input  wire logic [rpg_pkg::LEN_W-1:0]    list_len,
    output logic      [rpg_pkg::ROW_BITS-1:0] row_data
);
    import rpg_pkg::*;

    logic [ROW_BITS-1:0] mem [MAP_ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;
    logic [ROW_AW-1:0]   rd_row_reg;
    logic [MAP_ROWS-1:0] valid_reg;
    logic [MAP_ROWS-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_row] <= req.wr_data;
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_row];
            rd_row_reg  <= req.rd_row;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (req.start)
            valid_next = '0;
        else if (req.wr_en)
            valid_next[req.wr_row] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Rows not written since the list started read as the start pattern.
    assign row_data = valid_reg[rd_row_reg] ? rd_data_reg : init_row(rd_row_reg, list_len);

endmodule
`default_nettype wire

### design/rpg_ctrl.sv
// Draw sequencer: scales the fraction, scans map rows for the k-th free slot.
`default_nettype none
module rpg_ctrl #(
    parameter int MAX_ITEMS = rpg_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rpg_pkg::FRAC_IN_W-1:0] random_fraction,
    input  wire logic [rpg_pkg::LEN_W-1:0]     eff_len,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [rpg_pkg::POS_W-1:0]     position,
    output logic      [rpg_pkg::RANK_W-1:0]    rank,
    output logic                               last_of_list,
    output rpg_pkg::map_req_t                  map_req,
    input  wire logic [rpg_pkg::ROW_BITS-1:0]  row_data,
    output logic      [rpg_pkg::LEN_W-1:0]     list_len
);
    import rpg_pkg::*;

    localparam int PROD_W = FRACTION_BITS + LEN_W;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'((MAX_ITEMS - 1) / ROW_BITS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t              state_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [RANK_W-1:0]   rank_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [POS_W-1:0]    k_reg;
    logic [LEN_W-1:0]    seen_reg;
    logic [ROW_AW-1:0]   row_reg;
    logic                out_valid_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [RANK_W-1:0]   rank_out_reg;
    logic                last_reg;

    logic                     accept;
    logic                     new_list;
    logic [LEN_W-1:0]         rem_eff;
    logic [FRACTION_BITS-1:0] frac_used;
    logic [PROD_W-1:0]        prod;
    logic [LEN_W-1:0]         k_raw;
    logic [LEN_W-1:0]         k_clamp;
    logic [ROW_BITS-1:0]      free_bits;
    logic [CNT_W-1:0]         free_cnt;
    logic [LEN_W-1:0]         offset;
    logic                     found;
    logic [ROW_IW-1:0]        sel_bit;
    logic [ROW_BITS-1:0]      sel_mask;
    logic [CNT_W-1:0]         run_cnt;
    logic                     hit;
    logic                     out_free;
    logic                     commit;
    logic [LEN_W-1:0]         rem_dec;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign new_list  = (rem_reg == '0);
    assign rem_eff   = new_list ? eff_len : rem_reg;
    assign frac_used = FRACTION_BITS'(random_fraction);
    assign prod      = PROD_W'(frac_used) * PROD_W'(rem_eff);
    assign k_raw     = prod[PROD_W-1:FRACTION_BITS];
    assign k_clamp   = (k_raw >= rem_eff) ? (rem_eff - LEN_W'(1)) : k_raw;

    assign free_bits = ~row_data;
    assign free_cnt  = popcount_row(free_bits);
    assign offset    = LEN_W'(k_reg) - seen_reg;
    assign found     = (offset < LEN_W'(free_cnt)) || (row_reg == LAST_ROW);

    // Pick the offset-th free bit within the current row.
    always_comb
    begin
        sel_bit  = '0;
        sel_mask = '0;
        run_cnt  = '0;
        hit      = 1'b0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            if (free_bits[i])
            begin
                if (!hit && (run_cnt == offset[CNT_W-1:0]))
                begin
                    hit         = 1'b1;
                    sel_bit     = ROW_IW'(i);
                    sel_mask[i] = 1'b1;
                end
                run_cnt = run_cnt + CNT_W'(1);
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign commit   = (state_reg == S_SCAN) && found && out_free;
    assign rem_dec  = rem_reg - LEN_W'(1);

    always_comb
    begin
        map_req.start   = accept && new_list;
        map_req.rd_en   = accept || ((state_reg == S_SCAN) && !found);
        map_req.rd_row  = accept ? '0 : (row_reg + ROW_AW'(1));
        map_req.wr_en   = commit;
        map_req.wr_row  = row_reg;
        map_req.wr_data = row_data | sel_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rem_reg       <= '0;
            rank_reg      <= RANK_W'(1);
            len_reg       <= LEN_RESET;
            k_reg         <= '0;
            seen_reg      <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (new_list)
                        begin
                            len_reg  <= eff_len;
                            rem_reg  <= eff_len;
                            rank_reg <= RANK_W'(1);
                        end
                        k_reg     <= k_clamp[POS_W-1:0];
                        seen_reg  <= '0;
                        row_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (commit)
                    begin
                        rem_reg   <= rem_dec;
                        rank_reg  <= rank_reg + RANK_W'(1);
                        state_reg <= S_IDLE;
                    end
                    else if (!found)
                    begin
                        // advance to the next row, carrying the free count
                        seen_reg <= seen_reg + LEN_W'(free_cnt);
                        row_reg  <= row_reg + ROW_AW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            pos_reg      <= {row_reg, sel_bit};
            rank_out_reg <= rank_reg;
            last_reg     <= (rem_dec == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign position     = pos_reg;
    assign rank         = rank_out_reg;
    assign last_of_list = last_reg;
    assign list_len     = len_reg;

endmodule
`default_nettype wire

### design/random_permutation_generator.sv
// Random permutation generator: sampling without replacement over a taken map.
//
// Input channel (in_valid/in_ready, random_fraction) takes one 16-bit uniform
// fraction per draw. Output channel (out_valid/out_ready) returns one word per
// draw: the chosen position, its rank (1 upward) and last_of_list on the draw
// that completes the permutation. The next draw after that starts a new list.
// list_length is written through cfg_we/cfg_wdata; it is used when a list starts.
// Timing: one item at a time. After acceptance the map RAM is scanned one
// 8-position row per cycle until the row holding the k-th free slot is found.
// The output word is registered once that row is found and the output register
// is free, and in_ready rises with it.
// The output word sits in a register: when the receiver stalls, the block takes
// one more draw, scans to its row and holds it there with in_ready low until
// the register frees.
// Reset clears the list state so the first draw starts a new list; list_length
// returns to 64. No clearing pass is needed, since rows carry valid bits.
`default_nettype none
module random_permutation_generator #(
    parameter int MAX_ITEMS = rpg_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rpg_pkg::LEN_W-1:0]     cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rpg_pkg::FRAC_IN_W-1:0] random_fraction,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [rpg_pkg::POS_W-1:0]     position,
    output logic      [rpg_pkg::RANK_W-1:0]    rank,
    output logic                               last_of_list
);
    import rpg_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ITEMS);

    logic [LEN_W-1:0]    list_length_reg;
    logic [LEN_W-1:0]    eff_len;
    logic [LEN_W-1:0]    list_len;
    logic [ROW_BITS-1:0] row_data;
    map_req_t            map_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            list_length_reg <= LEN_RESET;
        else if (cfg_we)
            list_length_reg <= cfg_wdata;
    end

    assign eff_len = eff_length(list_length_reg, MAX_LEN);

    rpg_map_mem u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (map_req),
        .list_len (list_len),
        .row_data (row_data)
    );

    rpg_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .random_fraction (random_fraction),
        .eff_len         (eff_len),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .position        (position),
        .rank            (rank),
        .last_of_list    (last_of_list),
        .map_req         (map_req),
        .row_data        (row_data),
        .list_len        (list_len)
    );

endmodule
`default_nettype wire

### design/rpg_checker.sv
// Port-level checker for the permutation generator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module rpg_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [rpg_pkg::FRAC_IN_W-1:0] random_fraction,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [rpg_pkg::POS_W-1:0]     position,
    input wire logic [rpg_pkg::RANK_W-1:0]    rank,
    input wire logic                          last_of_list
);
    import rpg_pkg::*;

    localparam int SLOTS = 1 << POS_W;

    logic [RANK_W-1:0]       exp_rank_reg;
    logic [SLOTS-1:0]        used_reg;
    logic                    out_take;
    logic                    out_stall;
    logic                    in_take;
    logic                    in_wait;
    logic [POS_W+RANK_W:0]   out_word;

    assign out_take  = out_valid && out_ready;
    assign out_stall = out_valid && !out_ready;
    assign in_take   = in_valid && in_ready;
    assign in_wait   = in_valid && !in_ready;
    assign out_word  = {position, rank, last_of_list};

    // Track the rank sequence and the positions already handed out in this list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_rank_reg <= RANK_W'(1);
            used_reg     <= '0;
        end
        else if (out_take)
        begin
            if (last_of_list)
            begin
                exp_rank_reg <= RANK_W'(1);
                used_reg     <= '0;
            end
            else
            begin
                exp_rank_reg       <= rank + RANK_W'(1);
                used_reg[position] <= 1'b1;
            end
        end
    end

    `RPG_ASSERT_NEXT(a_one_item, clk, rst_n, in_take, !in_ready, "input taken mid-draw")
    `RPG_ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait,
        in_valid && $stable(random_fraction), "input word changed while waiting")
    `RPG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word),
        "output word changed while stalled")
    `RPG_ASSERT_IMPL(a_rank_seq, clk, rst_n, out_valid, rank == exp_rank_reg,
        "rank out of sequence")
    `RPG_ASSERT_IMPL(a_pos_unique, clk, rst_n, out_valid, !used_reg[position],
        "position repeated within a list")

endmodule

bind random_permutation_generator rpg_checker u_rpg_checker (.*);
`default_nettype wire

### sim/tb.sv
// Testbench for the random permutation generator: scripted and random draws checked by a model.
module tb;
    import rpg_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS   = 136;
    localparam int LONG_HOLD     = 400;
    localparam int PRESSURE_PHASE = 4;

    typedef enum logic {ROW_DRAW, ROW_LEN} row_kind_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [RANK_W-1:0] rank;
        logic              last;
    } draw_t;

    typedef struct packed {
        logic  known;
        draw_t exp;
    } mark_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [FRAC_IN_W-1:0] value;
        logic                 known;
        draw_t                exp;
    } script_row_t;

    // Expected words are typed in only for the opening draws of the reset-length list.
    localparam script_row_t SCRIPT [11] = '{
        '{ROW_DRAW, 16'h0000, 1'b1, '{6'd0,  7'd1, 1'b0}},
        '{ROW_DRAW, 16'hFFFF, 1'b1, '{6'd63, 7'd2, 1'b0}},
        '{ROW_DRAW, 16'h8000, 1'b0, '0},
        '{ROW_LEN,  16'd0,    1'b0, '0},
        '{ROW_DRAW, 16'h0001, 1'b0, '0},
        '{ROW_DRAW, 16'hFFFE, 1'b0, '0},
        '{ROW_DRAW, 16'h5555, 1'b0, '0},
        '{ROW_DRAW, 16'hAAAA, 1'b0, '0},
        '{ROW_LEN,  16'd127,  1'b0, '0},
        '{ROW_DRAW, 16'h00FF, 1'b0, '0},
        '{ROW_DRAW, 16'hFF00, 1'b0, '0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [LEN_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic [FRAC_IN_W-1:0] random_fraction;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [POS_W-1:0]     position;
    logic [RANK_W-1:0]    rank;
    logic                 last_of_list;

    random_permutation_generator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .random_fraction(random_fraction),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .position       (position),
        .rank           (rank),
        .last_of_list   (last_of_list)
    );

    // Model state of the draw
    logic [63:0]       taken_map   = '0;
    logic [LEN_W-1:0]  free_count  = '0;
    logic [RANK_W-1:0] next_rank   = 7'd1;
    logic [LEN_W-1:0]  len_setting = LEN_RESET;

    draw_t pending_draws[$];
    mark_t marks[$];
    int    errors        = 0;
    int    cycles        = 0;
    int    send_pct      = 0;
    int    recv_pct      = 0;
    int    hold_requests = 0;
    int    hold_served   = 0;
    int    hold_left     = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic draw_t draw_position(input logic [FRAC_IN_W-1:0] frac);
        logic [LEN_W-1:0] len;
        logic [22:0]      prod;
        logic [LEN_W-1:0] k;
        logic [LEN_W-1:0] seen;
        logic             found;
        draw_t            d;
        if (free_count == 0)
        begin
            len = len_setting;
            if (len == 0)
                len = 7'd1;
            else if (len > 7'd64)
                len = 7'd64;
            taken_map  = (len == 7'd64) ? 64'd0 : ~((64'd1 << len) - 64'd1);
            free_count = len;
            next_rank  = 7'd1;
        end
        prod = frac * free_count;
        k    = prod[22:16];
        if (k >= free_count)
            k = free_count - 7'd1;
        d     = '0;
        seen  = '0;
        found = 1'b0;
        for (int i = 0; i < 64; i++)
        begin
            if (!taken_map[i])
            begin
                if (!found && seen == k)
                begin
                    d.pos = POS_W'(i);
                    found = 1'b1;
                end
                seen = seen + 7'd1;
            end
        end
        taken_map[d.pos] = 1'b1;
        d.rank     = next_rank;
        free_count = free_count - 7'd1;
        next_rank  = next_rank + 7'd1;
        d.last     = (free_count == 0);
        return d;
    endfunction

    always @(posedge clk)
    begin : watch_inputs
        mark_t m;
        draw_t d;
        if (rst_n)
        begin
            if (cfg_we)
                len_setting = cfg_wdata;
            if (in_valid && in_ready)
            begin
                d = draw_position(random_fraction);
                m = marks.pop_front();
                pending_draws.push_back(m.known ? m.exp : d);
            end
        end
    end

    always @(posedge clk)
    begin : check_outputs
        draw_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_draws.size() == 0)
            begin
                $display("%0t: word with nothing expected: position=%0d rank=%0d last=%0b",
                         $time, position, rank, last_of_list);
                errors++;
            end
            else
            begin
                want = pending_draws.pop_front();
                if (position !== want.pos)
                begin
                    $display("%0t: position expected %0d actual %0d", $time, want.pos, position);
                    errors++;
                end
                if (rank !== want.rank)
                begin
                    $display("%0t: rank expected %0d actual %0d", $time, want.rank, rank);
                    errors++;
                end
                if (last_of_list !== want.last)
                begin
                    $display("%0t: last_of_list expected %0b actual %0b",
                             $time, want.last, last_of_list);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != hold_served)
        begin
            out_ready   <= 1'b0;
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [FRAC_IN_W-1:0] frac, input mark_t mark);
        if (send_pct != 0 && $urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_pct)
                @(posedge clk);
        end
        marks.push_back(mark);
        in_valid        <= 1'b1;
        random_fraction <= frac;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every draw has come back and the scan is done
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        idle_mode_t           mode;
        logic [FRAC_IN_W-1:0] frac;
        logic [LEN_W-1:0]     len_pick;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        in_valid        <= 1'b0;
        random_fraction <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].kind == ROW_LEN)
                write_length(SCRIPT[i].value[LEN_W-1:0]);
            else
                send_word(SCRIPT[i].value, '{SCRIPT[i].known, SCRIPT[i].exp});
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            mode = idle_mode_t'(p % 4);
            case (p)
                0: len_pick = 7'd1;
                1: len_pick = 7'd127;
                2: len_pick = 7'd64;
                3: len_pick = 7'd2;
                5: len_pick = 7'd0;
                7: len_pick = 7'd65;
                default:
                    len_pick = ($urandom_range(1) != 0) ? LEN_W'($urandom_range(16))
                                                        : LEN_W'($urandom_range(127));
            endcase
            write_length(len_pick);
            case (mode)
                IDLE_NONE: begin send_pct = 0;  recv_pct <= 0;  end
                IDLE_SEND: begin send_pct = 78; recv_pct <= 0;  end
                IDLE_RECV: begin send_pct = 0;  recv_pct <= 78; end
                default:   begin send_pct = 9;  recv_pct <= 9;  end
            endcase
            // Hold the receiver off so the block fills and stalls its input
            if (p == PRESSURE_PHASE)
                hold_requests <= hold_requests + 1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                case ($urandom_range(9))
                    0:       frac = 16'h0000;
                    1:       frac = 16'hFFFF;
                    default: frac = FRAC_IN_W'($urandom);
                endcase
                send_word(frac, '0);
            end
        end

        settle();
        if (errors == 0 && pending_draws.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
